[design/lru_key_value_cache_core_defines.svh]
// ---------------------------------------------------------------------------
// lru key-value cache assertion macros
// clocked assertion helpers used by the cache core rtl
// ---------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH
`define LRU_KEY_VALUE_CACHE_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define LRUKV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define LRUKV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LRUKV_ASSERT(lbl, prop, msg)

`define LRUKV_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

[design/lrukv_pkg.sv]
// ---------------------------------------------------------------------------
// lru key-value cache package
// field widths, operation codes and the types passed along the cell chain
// ---------------------------------------------------------------------------
package lrukv_pkg;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CFG_W = 5;

  localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

  localparam logic MODE_GET = 1'b0;
  localparam logic MODE_PUT = 1'b1;

  typedef struct packed {
    logic                    valid;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic                    act;
    logic                    hit;
    logic                    evict;
    logic signed [KEY_W-1:0] key;
  } cell_ctl_t;

endpackage

[design/lrukv_cell.sv]
// ---------------------------------------------------------------------------
// lru key-value cache cell
// one recency position: holds an entry, compares its key, and on an update
// takes the entry of the next more recent position
// ---------------------------------------------------------------------------
module lrukv_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  lrukv_pkg::cell_ctl_t ctl,
  input  lrukv_pkg::entry_t  prev_entry,
  input  logic               next_valid,
  input  logic               below_match_in,
  output lrukv_pkg::entry_t  entry,
  output logic               match,
  output logic               below_match_out,
  output logic               is_tail
);

  logic                              valid_r;
  logic                              valid_nxt;
  logic signed [lrukv_pkg::KEY_W-1:0] key_r;
  logic signed [lrukv_pkg::VAL_W-1:0] value_r;
  logic                              shift;

  assign match           = valid_r && (key_r == ctl.key);
  assign below_match_out = match | below_match_in;
  assign is_tail         = valid_r & ~next_valid;

  // hit: positions up to the hit one move; miss: fill or drop the tail
  assign shift = ctl.act &&
                 (ctl.hit ? below_match_out
                          : (prev_entry.valid && (valid_r || !ctl.evict)));

  assign valid_nxt = shift ? prev_entry.valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key_r   <= prev_entry.key;
      value_r <= prev_entry.value;
    end
  end

  assign entry.valid = valid_r;
  assign entry.key   = key_r;
  assign entry.value = value_r;

endmodule

[design/lru_key_value_cache_core.sv]
// ---------------------------------------------------------------------------
// lru key-value cache core
// A fully associative key-value store with least recently used replacement.
// Entries sit in a chain of cells ordered by recency, the most recent in
// cell 0; every cell compares its key against the incoming word in parallel.
// A get or put word is accepted on a clock edge; the chain updates on
// the same edge and the result word is registered at the output, so one word
// per cycle is sustained while the output is taken. A hit moves its entry to
// the head and shifts the more recent ones back; a put miss inserts at the
// head and drops the tail entry when occupancy has reached the capacity set
// in cfg (0 acts as 1, values above ENTRIES act as ENTRIES). Reset empties
// the cache and sets the capacity to 16.
// ---------------------------------------------------------------------------
`include "lru_key_value_cache_core_defines.svh"

module lru_key_value_cache_core #(
  parameter int ENTRIES = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [lrukv_pkg::CFG_W-1:0]       cfg_wr_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_mode,
  input  logic signed [lrukv_pkg::KEY_W-1:0] in_lookup_key,
  input  logic signed [lrukv_pkg::VAL_W-1:0] in_write_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic signed [lrukv_pkg::VAL_W-1:0] out_read_value,
  output logic                              out_evicted,
  output logic signed [lrukv_pkg::KEY_W-1:0] out_evicted_key
);

  localparam int OCC_W = $clog2(ENTRIES + 1);
  localparam int CMP_W = (OCC_W > lrukv_pkg::CFG_W) ? OCC_W : lrukv_pkg::CFG_W;

  logic [lrukv_pkg::CFG_W-1:0] active_entries_r;
  logic [OCC_W-1:0]            occ_r;
  logic [OCC_W-1:0]            occ_nxt;

  logic [CMP_W-1:0] cfg_ext;
  logic [CMP_W-1:0] cap;
  logic             cap_full;

  logic in_fire;
  logic is_put;
  logic hit;
  logic put_miss;
  logic evict_now;

  lrukv_pkg::entry_t    ent [ENTRIES];
  lrukv_pkg::entry_t    new_entry;
  lrukv_pkg::cell_ctl_t ctl;
  logic [ENTRIES-1:0]   match_vec;
  logic [ENTRIES-1:0]   valid_vec;
  logic [ENTRIES-1:0]   tail_vec;
  logic [ENTRIES:0]     below;

  logic signed [lrukv_pkg::VAL_W-1:0] hit_value;
  logic signed [lrukv_pkg::KEY_W-1:0] tail_key;

  logic                              out_valid_r;
  logic                              out_hit_r;
  logic signed [lrukv_pkg::VAL_W-1:0] out_read_value_r;
  logic                              out_evicted_r;
  logic signed [lrukv_pkg::KEY_W-1:0] out_evicted_key_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_entries_r <= lrukv_pkg::ACTIVE_RESET;
    end else if (cfg_wr_en) begin
      active_entries_r <= cfg_wr_data;
    end
  end

  assign cfg_ext = CMP_W'(active_entries_r);

  always_comb begin
    if (cfg_ext == '0) begin
      cap = CMP_W'(1);
    end else if (cfg_ext > CMP_W'(ENTRIES)) begin
      cap = CMP_W'(ENTRIES);
    end else begin
      cap = cfg_ext;
    end
  end

  assign cap_full = CMP_W'(occ_r) >= cap;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_fire   = in_valid && in_ready;
  assign is_put    = (in_mode == lrukv_pkg::MODE_PUT);
  assign hit       = below[0];
  assign put_miss  = is_put && !hit;
  assign evict_now = put_miss && cap_full;

  assign ctl.act   = in_fire && (hit || is_put);
  assign ctl.hit   = hit;
  assign ctl.evict = evict_now;
  assign ctl.key   = in_lookup_key;

  assign new_entry.valid = 1'b1;
  assign new_entry.key   = in_lookup_key;
  assign new_entry.value = is_put ? in_write_value : hit_value;

  assign below[ENTRIES] = 1'b0;

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    lrukv_pkg::entry_t prev_entry;
    logic              next_valid;

    if (i == 0) begin : g_head
      assign prev_entry = new_entry;
    end else begin : g_body
      assign prev_entry = ent[i-1];
    end

    if (i == ENTRIES - 1) begin : g_last
      assign next_valid = 1'b0;
    end else begin : g_inner
      assign next_valid = ent[i+1].valid;
    end

    lrukv_cell u_cell (
      .clk             (clk),
      .rst_n           (rst_n),
      .ctl             (ctl),
      .prev_entry      (prev_entry),
      .next_valid      (next_valid),
      .below_match_in  (below[i+1]),
      .entry           (ent[i]),
      .match           (match_vec[i]),
      .below_match_out (below[i]),
      .is_tail         (tail_vec[i])
    );

    assign valid_vec[i] = ent[i].valid;
  end

  always_comb begin
    hit_value = '0;
    tail_key  = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      hit_value = hit_value | (ent[i].value & {lrukv_pkg::VAL_W{match_vec[i]}});
      tail_key  = tail_key  | (ent[i].key   & {lrukv_pkg::KEY_W{tail_vec[i]}});
    end
  end

  assign occ_nxt = (in_fire && put_miss && !cap_full) ? occ_r + OCC_W'(1) : occ_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
      if (in_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_hit_r         <= hit;
      out_read_value_r  <= (hit && !is_put) ? hit_value : '0;
      out_evicted_r     <= evict_now;
      out_evicted_key_r <= evict_now ? tail_key : '0;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_read_value_r;
  assign out_evicted     = out_evicted_r;
  assign out_evicted_key = out_evicted_key_r;

  `LRUKV_ASSERT(a_unique_match, $onehot0(match_vec), "more than one cell matched the key")
  `LRUKV_ASSERT(a_occ_count, ($countones(valid_vec) == int'(occ_r)), "occupancy disagrees with valid cells")
  `LRUKV_ASSERT(a_occ_bound, (int'(occ_r) <= ENTRIES), "occupancy above entry count")
  `LRUKV_ASSERT(a_evict_reported, (in_fire && evict_now) |=> (out_valid_r && out_evicted_r), "eviction not reported")
  `LRUKV_ASSERT(a_get_keeps_occ, (in_fire && !is_put) |=> $stable(occ_r), "get changed occupancy")

endmodule

[bench/lru_key_value_cache_core_tb.sv]
// ---------------------------------------------------------------------------
// lru key-value cache core testbench
// Drives get and put words through the valid/ready input channel, predicts
// hit, read value and eviction with a slot-and-age model of the cache, and
// checks every result word in order. Walks several capacity settings,
// including zero, the full store and values above it, under random gaps on
// both channels and a long output hold-off.
// ---------------------------------------------------------------------------
module lru_key_value_cache_core_tb;

  localparam int SLOTS = 16;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PRINT_LIMIT = 50;

  typedef struct packed {
    logic                               mode;
    logic signed [lrukv_pkg::KEY_W-1:0] key;
    logic signed [lrukv_pkg::VAL_W-1:0] value;
  } access_t;

  typedef struct packed {
    logic                               hit;
    logic signed [lrukv_pkg::VAL_W-1:0] read_value;
    logic                               evicted;
    logic signed [lrukv_pkg::KEY_W-1:0] evicted_key;
  } reply_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               cfg_wr_en = 1'b0;
  logic [lrukv_pkg::CFG_W-1:0]        cfg_wr_data = '0;
  logic                               in_valid = 1'b0;
  logic                               in_ready;
  logic                               in_mode = lrukv_pkg::MODE_GET;
  logic signed [lrukv_pkg::KEY_W-1:0] in_lookup_key = '0;
  logic signed [lrukv_pkg::VAL_W-1:0] in_write_value = '0;
  logic                               out_valid;
  logic                               out_ready = 1'b0;
  logic                               out_hit;
  logic signed [lrukv_pkg::VAL_W-1:0] out_read_value;
  logic                               out_evicted;
  logic signed [lrukv_pkg::KEY_W-1:0] out_evicted_key;

  access_t pending_accesses[$];
  reply_t  due_replies[$];

  // predicted cache contents
  logic [lrukv_pkg::KEY_W-1:0] slot_key[SLOTS];
  logic [lrukv_pkg::VAL_W-1:0] slot_value[SLOTS];
  logic                        slot_live[SLOTS];
  int                          slot_age[SLOTS];
  int                          live_count = 0;
  logic [lrukv_pkg::CFG_W-1:0] capacity_setting = lrukv_pkg::ACTIVE_RESET;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int mismatches = 0;
  int puts_sent = 0;
  int gets_sent = 0;
  int hits_seen = 0;
  int evictions_seen = 0;
  int settings_used = 1;

  lru_key_value_cache_core #(.ENTRIES(SLOTS)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_mode        (in_mode),
    .in_lookup_key  (in_lookup_key),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted),
    .out_evicted_key(out_evicted_key)
  );

  always #4 clk = ~clk;

  function automatic reply_t apply_access(access_t a);
    reply_t r;
    int     found;
    int     lru;
    int     free_slot;
    int     cap;
    int     age_ref;
    r = '0;
    found = -1;
    lru = -1;
    free_slot = -1;
    for (int i = 0; i < SLOTS; i++)
      if (found < 0 && slot_live[i] && slot_key[i] == a.key) found = i;
    if (found >= 0) begin
      r.hit = 1'b1;
      if (a.mode == lrukv_pkg::MODE_PUT) slot_value[found] = a.value;
      else r.read_value = slot_value[found];
      age_ref = slot_age[found];
      for (int i = 0; i < SLOTS; i++)
        if (slot_live[i] && i != found && slot_age[i] < age_ref) slot_age[i]++;
      slot_age[found] = 0;
    end else if (a.mode == lrukv_pkg::MODE_PUT) begin
      cap = int'(capacity_setting);
      if (cap < 1) cap = 1;
      if (cap > SLOTS) cap = SLOTS;
      if (live_count >= cap) begin
        for (int i = 0; i < SLOTS; i++)
          if (slot_live[i] && (lru < 0 || slot_age[i] > slot_age[lru])) lru = i;
        if (lru >= 0) begin
          r.evicted = 1'b1;
          r.evicted_key = slot_key[lru];
          slot_live[lru] = 1'b0;
          slot_age[lru] = 0;
          if (live_count > 0) live_count--;
        end
      end
      for (int i = 0; i < SLOTS; i++)
        if (free_slot < 0 && !slot_live[i]) free_slot = i;
      if (free_slot >= 0) begin
        for (int i = 0; i < SLOTS; i++)
          if (slot_live[i]) slot_age[i]++;
        slot_live[free_slot] = 1'b1;
        slot_key[free_slot] = a.key;
        slot_value[free_slot] = a.value;
        slot_age[free_slot] = 0;
        live_count++;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [lrukv_pkg::KEY_W-1:0] got,
                                 logic [lrukv_pkg::KEY_W-1:0] want);
    if (mismatches < PRINT_LIMIT)
      $display("mismatch at cycle %0d: %s got %h want %h", cycle_count, what, got, want);
    mismatches++;
  endtask

  // driver
  always @(posedge clk) begin
    access_t a;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        a = pending_accesses.pop_front();
        due_replies.push_back(apply_access(a));
        if (a.mode == lrukv_pkg::MODE_PUT) puts_sent++;
        else gets_sent++;
      end
      if (in_valid && !in_ready) begin
        // hold the word until taken
      end else if (pending_accesses.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_mode <= pending_accesses[0].mode;
        in_lookup_key <= pending_accesses[0].key;
        in_write_value <= pending_accesses[0].value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    reply_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_replies.size() == 0) begin
          report_mismatch("unexpected result word, evicted_key", out_evicted_key, '0);
        end else begin
          want = due_replies.pop_front();
          if (out_hit !== want.hit) report_mismatch("hit", out_hit, want.hit);
          if (out_read_value !== want.read_value)
            report_mismatch("read_value", out_read_value, want.read_value);
          if (out_evicted !== want.evicted)
            report_mismatch("evicted", out_evicted, want.evicted);
          if (out_evicted_key !== want.evicted_key)
            report_mismatch("evicted_key", out_evicted_key, want.evicted_key);
          if (want.hit) hits_seen++;
          if (want.evicted) evictions_seen++;
        end
      end
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Verification failed");
      $finish;
    end
  end

  task automatic queue_access(logic mode, logic [lrukv_pkg::KEY_W-1:0] key,
                              logic [lrukv_pkg::VAL_W-1:0] value);
    access_t a;
    a.mode = mode;
    a.key = key;
    a.value = value;
    pending_accesses.push_back(a);
  endtask

  task automatic wait_idle();
    while (pending_accesses.size() != 0 || due_replies.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_capacity(logic [lrukv_pkg::CFG_W-1:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    capacity_setting = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    settings_used++;
  endtask

  // random words over a key pool sized to the capacity so hits and evictions mix
  task automatic queue_random_words(int count, int cap);
    logic [lrukv_pkg::KEY_W-1:0] pool[];
    int                          pool_size;
    logic [lrukv_pkg::KEY_W-1:0] key;
    pool_size = cap + cap / 2 + 2;
    pool = new[pool_size];
    foreach (pool[i]) begin
      case ($urandom_range(15))
        0: pool[i] = 32'h8000_0000;
        1: pool[i] = 32'h7fff_ffff;
        2: pool[i] = 32'hffff_ffff;
        3: pool[i] = 32'h0000_0000;
        default: pool[i] = $urandom;
      endcase
    end
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 82) key = pool[$urandom_range(pool_size - 1)];
      else key = $urandom;
      queue_access($urandom_range(1) ? lrukv_pkg::MODE_PUT : lrukv_pkg::MODE_GET, key,
                   $urandom);
    end
  endtask

  initial begin
    logic [lrukv_pkg::CFG_W-1:0] caps[10];
    int                          eff;
    caps = '{5'd16, 5'd4, 5'd1, 5'd31, 5'd0, 5'd9, 5'd17, 5'd2, 5'd16, 5'd5};
    for (int i = 0; i < SLOTS; i++) begin
      slot_key[i] = '0;
      slot_value[i] = '0;
      slot_live[i] = 1'b0;
      slot_age[i] = 0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, both operations, hits and misses at reset capacity
    @(negedge clk);
    queue_access(lrukv_pkg::MODE_GET, 32'h0000_0000, 32'h1111_1111);
    queue_access(lrukv_pkg::MODE_PUT, 32'h8000_0000, 32'h7fff_ffff);
    queue_access(lrukv_pkg::MODE_PUT, 32'h7fff_ffff, 32'h8000_0000);
    queue_access(lrukv_pkg::MODE_GET, 32'h8000_0000, 32'h0000_0000);
    queue_access(lrukv_pkg::MODE_GET, 32'h7fff_ffff, 32'hffff_ffff);
    queue_access(lrukv_pkg::MODE_PUT, 32'h8000_0000, 32'hffff_ffff);
    queue_access(lrukv_pkg::MODE_GET, 32'hffff_ffff, 32'h0000_0000);
    queue_access(lrukv_pkg::MODE_PUT, 32'hffff_ffff, 32'h0000_0000);
    queue_access(lrukv_pkg::MODE_PUT, 32'h0000_0000, 32'h5a5a_5a5a);
    queue_access(lrukv_pkg::MODE_GET, 32'h8000_0000, 32'h0000_0000);
    wait_idle();

    // capacity lowered below occupancy: each put miss evicts one entry
    write_capacity(5'd2);
    @(negedge clk);
    queue_access(lrukv_pkg::MODE_PUT, 32'h1234_5678, 32'h0000_0001);
    queue_access(lrukv_pkg::MODE_PUT, 32'h0000_ffff, 32'ha5a5_a5a5);
    queue_access(lrukv_pkg::MODE_GET, 32'h1234_5678, 32'h0000_0000);
    queue_access(lrukv_pkg::MODE_PUT, 32'h0001_0000, 32'h8000_0000);
    queue_access(lrukv_pkg::MODE_GET, 32'h7fff_ffff, 32'h0000_0000);
    wait_idle();

    // capacity zero acts as one
    write_capacity(5'd0);
    @(negedge clk);
    queue_access(lrukv_pkg::MODE_PUT, 32'h5555_5555, 32'haaaa_aaaa);
    queue_access(lrukv_pkg::MODE_PUT, 32'haaaa_aaaa, 32'h5555_5555);
    queue_access(lrukv_pkg::MODE_GET, 32'haaaa_aaaa, 32'h0000_0000);
    queue_access(lrukv_pkg::MODE_GET, 32'h5555_5555, 32'h0000_0000);
    queue_access(lrukv_pkg::MODE_PUT, 32'haaaa_aaaa, 32'h0000_0000);
    wait_idle();

    for (int p = 0; p < 10; p++) begin
      write_capacity(caps[p]);
      eff = int'(caps[p]);
      if (eff < 1) eff = 1;
      if (eff > SLOTS) eff = SLOTS;
      @(negedge clk);
      if (p < 4) begin
        send_idle_pct = 36;
        recv_idle_pct = 56;
      end else if (p < 7) begin
        send_idle_pct = 56;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // long output stall while input keeps coming
      if (p == 1 || p == 8) hold_left = 150;
      queue_random_words(175, eff);
      wait_idle();
    end

    repeat (8) @(posedge clk);
    if (due_replies.size() != 0)
      report_mismatch("results never arrived, count", due_replies.size(), '0);
    $display("ran %0d puts and %0d gets over %0d capacity settings", puts_sent, gets_sent,
             settings_used);
    $display("saw %0d hits and %0d evictions", hits_seen, evictions_seen);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
